// ----- hw/rtl/psm_pkg.sv -----
package psm_pkg;

  localparam int COORD_W    = 16;
  localparam int OFFSET_W   = 32;
  localparam int VALUE_W    = 32;
  localparam int THRESH_W   = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int COL_W      = 2;

  // Three rows of a column are worked on side by side.
  localparam int LANES = 3;

  // Products and sums on the way to the divider.
  localparam int PROD_W    = 2 * COORD_W;
  localparam int NUM_W     = COORD_W + OFFSET_W;
  localparam int NUM_MAG_W = NUM_W - 1;
  localparam int DOT_W     = PROD_W + 2;
  localparam int DOT_MAG_W = PROD_W;

  // Quotient bits kept before saturation takes over.
  localparam int QUOT_BITS = 34;
  localparam int SUM_W     = QUOT_BITS + 2;

  localparam int THRESH_SHIFT = 14;

  localparam logic [COL_W-1:0] LAST_COL = 2'd3;

  localparam logic signed [COORD_W-1:0] LIGHT_X_RESET = 16'sd0;
  localparam logic signed [COORD_W-1:0] LIGHT_Y_RESET = -16'sd16384;
  localparam logic signed [COORD_W-1:0] LIGHT_Z_RESET = 16'sd0;
  localparam logic [THRESH_W-1:0]       THRESH_RESET  = 15'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIGHT_X   = 2'd0,
    REG_LIGHT_Y   = 2'd1,
    REG_LIGHT_Z   = 2'd2,
    REG_THRESHOLD = 2'd3
  } cfg_reg_t;

  typedef logic signed [COORD_W-1:0] coord_t;

endpackage

// ----- hw/rtl/planar_shadow_matrix.sv -----
// Column 0 of a matrix is strobed after the accepted request passes the issue counter,
// stages 1 to 3, the divider setup stage, the divider stages and the output register;
// columns 1 to 3 follow it, one column per cycle. A new request is taken whenever busy
// is low: busy stays high after an accept while columns 0 to 2 issue into three pipelined divider lanes.
// Synchronous reset clears all valid bits and loads the light registers.
// The receiver cannot stall: every strobed column is taken in its cycle.
module planar_shadow_matrix #(
  parameter int FRACTION_BITS_OUT = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 write_enable,
  input  logic [psm_pkg::CFG_IDX_W-1:0]        write_index,
  input  logic [psm_pkg::CFG_DATA_W-1:0]       write_data,
  input  logic signed [psm_pkg::COORD_W-1:0]   normal_x,
  input  logic signed [psm_pkg::COORD_W-1:0]   normal_y,
  input  logic signed [psm_pkg::COORD_W-1:0]   normal_z,
  input  logic signed [psm_pkg::OFFSET_W-1:0]  plane_offset,
  output logic                                 result_valid,
  output logic [psm_pkg::COL_W-1:0]            column_index,
  output logic signed [psm_pkg::VALUE_W-1:0]   row0_value,
  output logic signed [psm_pkg::VALUE_W-1:0]   row1_value,
  output logic signed [psm_pkg::VALUE_W-1:0]   row2_value,
  output logic signed [psm_pkg::VALUE_W-1:0]   row3_value,
  output logic                                 degenerate,
  output logic                                 last_column
);
  import psm_pkg::*;

  localparam int SH_LIN = FRACTION_BITS_OUT;
  localparam int SH_TR  = FRACTION_BITS_OUT - 2;
  localparam int XW     = NUM_MAG_W + FRACTION_BITS_OUT;
  localparam int HIW    = XW - QUOT_BITS;
  localparam int CW     = HIW + DOT_MAG_W;

  localparam logic [VALUE_W-1:0] ONE_Q   = VALUE_W'(1) << FRACTION_BITS_OUT;
  localparam logic [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(VAL_MAX);
  localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

  // Configuration registers.
  logic signed [COORD_W-1:0] light_x;
  logic signed [COORD_W-1:0] light_y;
  logic signed [COORD_W-1:0] light_z;
  logic [THRESH_W-1:0]       parallel_threshold;
  coord_t                    light_v [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      light_x            <= LIGHT_X_RESET;
      light_y            <= LIGHT_Y_RESET;
      light_z            <= LIGHT_Z_RESET;
      parallel_threshold <= THRESH_RESET;
    end else if (write_enable) begin
      case (cfg_reg_t'(write_index))
        REG_LIGHT_X:   light_x <= signed'(write_data);
        REG_LIGHT_Y:   light_y <= signed'(write_data);
        REG_LIGHT_Z:   light_z <= signed'(write_data);
        REG_THRESHOLD: parallel_threshold <= write_data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  assign light_v[0] = light_x;
  assign light_v[1] = light_y;
  assign light_v[2] = light_z;

  // Request holding register and column issue counter.
  logic                       item_act;
  logic [COL_W-1:0]           beat_cnt;
  coord_t                     item_n [LANES];
  logic signed [OFFSET_W-1:0] item_off;
  logic                       accept;

  assign busy   = item_act && (beat_cnt != LAST_COL);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_act <= 1'b0;
      beat_cnt <= '0;
    end else if (accept) begin
      item_act <= 1'b1;
      beat_cnt <= '0;
    end else if (item_act) begin
      beat_cnt <= beat_cnt + COL_W'(1);
      if (beat_cnt == LAST_COL) begin
        item_act <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_n[0] <= normal_x;
      item_n[1] <= normal_y;
      item_n[2] <= normal_z;
      item_off  <= plane_offset;
    end
  end

  // Columns 0 to 2 scale the light by one normal component, column 3 by the offset.
  logic signed [OFFSET_W-1:0] mult_b;

  always_comb begin
    case (beat_cnt)
      2'd0:    mult_b = OFFSET_W'(item_n[0]);
      2'd1:    mult_b = OFFSET_W'(item_n[1]);
      2'd2:    mult_b = OFFSET_W'(item_n[2]);
      default: mult_b = item_off;
    endcase
  end

  // Stage 1: products.
  logic                     s1_valid;
  logic [COL_W-1:0]         s1_col;
  logic signed [PROD_W-1:0] s1_pn  [LANES];
  logic signed [NUM_W-1:0]  s1_num [LANES];

  // Stage 2: dot sum and numerator magnitudes.
  logic                     s2_valid;
  logic [COL_W-1:0]         s2_col;
  logic signed [DOT_W-1:0]  s2_dot;
  logic [NUM_MAG_W-1:0]     s2_nmag [LANES];
  logic                     s2_nneg [LANES];

  // Stage 3: divisor magnitude and aligned dividends.
  logic                     s3_valid;
  logic [COL_W-1:0]         s3_col;
  logic [DOT_MAG_W-1:0]     s3_dmag;
  logic [XW-1:0]            s3_x   [LANES];
  logic                     s3_neg [LANES];

  // Divider pipeline; entry 0 is the setup stage, one quotient bit per stage after.
  logic                     dv_valid [QUOT_BITS+1];
  logic [COL_W-1:0]         dv_col   [QUOT_BITS+1];
  logic                     dv_degen [QUOT_BITS+1];
  logic [DOT_MAG_W-1:0]     dv_dmag  [QUOT_BITS+1];
  logic [DOT_MAG_W-1:0]     dv_rem   [QUOT_BITS+1][LANES];
  logic [QUOT_BITS-1:0]     dv_word  [QUOT_BITS+1][LANES];
  logic                     dv_ovf   [QUOT_BITS+1][LANES];
  logic                     dv_neg   [QUOT_BITS+1][LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      s3_valid    <= 1'b0;
      dv_valid[0] <= 1'b0;
    end else begin
      s1_valid    <= item_act;
      s2_valid    <= s1_valid;
      s3_valid    <= s2_valid;
      dv_valid[0] <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_col      <= beat_cnt;
    s2_col      <= s1_col;
    s2_dot      <= DOT_W'(s1_pn[0]) + DOT_W'(s1_pn[1]) + DOT_W'(s1_pn[2]);
    s3_col      <= s2_col;
    s3_dmag     <= s2_dot[DOT_W-1] ? DOT_MAG_W'(-s2_dot) : DOT_MAG_W'(s2_dot);
    dv_col[0]   <= s3_col;
    dv_dmag[0]  <= s3_dmag;
    // A dot of exactly zero is parallel even when the threshold is zero.
    dv_degen[0] <= (s3_dmag == '0) ||
                   (s3_dmag < (DOT_MAG_W'(parallel_threshold) << THRESH_SHIFT));
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane_front
    logic [HIW-1:0] hi;

    assign hi = s3_x[k][XW-1:QUOT_BITS];

    always_ff @(posedge clk) begin
      s1_pn[k]   <= PROD_W'(item_n[k]) * PROD_W'(light_v[k]);
      s1_num[k]  <= NUM_W'(light_v[k]) * NUM_W'(mult_b);
      s2_nneg[k] <= s1_num[k][NUM_W-1];
      s2_nmag[k] <= s1_num[k][NUM_W-1] ? NUM_MAG_W'(-s1_num[k]) : NUM_MAG_W'(s1_num[k]);
      s3_neg[k]  <= s2_nneg[k] ^ s2_dot[DOT_W-1] ^ (s2_col != LAST_COL);
      s3_x[k]    <= (s2_col == LAST_COL) ? (XW'(s2_nmag[k]) << SH_TR)
                                         : (XW'(s2_nmag[k]) << SH_LIN);
      // A quotient that would need more than QUOT_BITS bits saturates anyway.
      dv_ovf[0][k]  <= CW'(hi) >= CW'(s3_dmag);
      dv_rem[0][k]  <= DOT_MAG_W'(hi);
      dv_word[0][k] <= s3_x[k][QUOT_BITS-1:0];
      dv_neg[0][k]  <= s3_neg[k];
    end
  end

  for (genvar st = 1; st <= QUOT_BITS; st++) begin : g_div_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[st] <= 1'b0;
      end else begin
        dv_valid[st] <= dv_valid[st-1];
      end
    end

    always_ff @(posedge clk) begin
      dv_col[st]   <= dv_col[st-1];
      dv_degen[st] <= dv_degen[st-1];
      dv_dmag[st]  <= dv_dmag[st-1];
    end

    for (genvar k = 0; k < LANES; k++) begin : g_div_lane
      logic [DOT_MAG_W:0] trial;
      logic               fits;

      // Dividend bits leave the top of the word as quotient bits enter below.
      assign trial = {dv_rem[st-1][k], dv_word[st-1][k][QUOT_BITS-1]};
      assign fits  = trial >= {1'b0, dv_dmag[st-1]};

      always_ff @(posedge clk) begin
        dv_rem[st][k]  <= fits ? DOT_MAG_W'(trial - {1'b0, dv_dmag[st-1]})
                               : trial[DOT_MAG_W-1:0];
        dv_word[st][k] <= {dv_word[st-1][k][QUOT_BITS-2:0], fits};
        dv_ovf[st][k]  <= dv_ovf[st-1][k];
        dv_neg[st][k]  <= dv_neg[st-1][k];
      end
    end
  end

  // Output stage: apply sign and identity term, then saturate; a degenerate column gives the identity term alone.
  logic [VALUE_W-1:0] out_row [LANES];

  for (genvar k = 0; k < LANES; k++) begin : g_lane_out
    logic signed [SUM_W-1:0] q_s;
    logic signed [SUM_W-1:0] delta;
    logic signed [SUM_W-1:0] sum_v;
    logic [VALUE_W-1:0]      row_next;

    always_comb begin
      q_s   = signed'(SUM_W'(dv_word[QUOT_BITS][k]));
      delta = (dv_col[QUOT_BITS] == COL_W'(k)) ? signed'(SUM_W'(ONE_Q)) : '0;
      sum_v = delta + (dv_neg[QUOT_BITS][k] ? -q_s : q_s);
      if (dv_degen[QUOT_BITS]) begin
        row_next = delta[VALUE_W-1:0];
      end else if (dv_ovf[QUOT_BITS][k]) begin
        row_next = dv_neg[QUOT_BITS][k] ? VAL_MIN : VAL_MAX;
      end else if (sum_v > SAT_HI) begin
        row_next = VAL_MAX;
      end else if (sum_v < SAT_LO) begin
        row_next = VAL_MIN;
      end else begin
        row_next = sum_v[VALUE_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      out_row[k] <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= dv_valid[QUOT_BITS];
    end
  end

  always_ff @(posedge clk) begin
    column_index <= dv_col[QUOT_BITS];
    degenerate   <= dv_degen[QUOT_BITS];
    last_column  <= dv_col[QUOT_BITS] == LAST_COL;
    row3_value   <= (dv_col[QUOT_BITS] == LAST_COL) ? signed'(ONE_Q) : '0;
  end

  assign row0_value = signed'(out_row[0]);
  assign row1_value = signed'(out_row[1]);
  assign row2_value = signed'(out_row[2]);

endmodule

// ----- hw/rtl/psm_checker.sv -----
module psm_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               start,
  input logic                               busy,
  input logic                               result_valid,
  input logic [psm_pkg::COL_W-1:0]          column_index,
  input logic signed [psm_pkg::VALUE_W-1:0] row3_value,
  input logic                               degenerate,
  input logic                               last_column
);
  import psm_pkg::*;

  // An accepted request holds off the next one for the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy did not rise after an accepted request");

  // The four columns of a matrix come out in order with no gap.
  a_columns_in_order: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_column |=>
      result_valid && (column_index == $past(column_index) + COL_W'(1)))
    else $error("matrix columns not consecutive");

  a_last_marks_col3: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (last_column == (column_index == LAST_COL)))
    else $error("last_column does not match column 3");

  // All columns of one matrix agree on the degenerate flag.
  a_degen_steady: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_column |=> degenerate == $past(degenerate))
    else $error("degenerate changed within a matrix");

  a_row3_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_column |-> row3_value == '0)
    else $error("row 3 not zero outside the translation column");

endmodule

bind planar_shadow_matrix psm_checker u_psm_checker (.*);
